[hw/rtl/cmt_pkg.sv]
// Shared types and constants for the compare-match timer unit.
package cmt_pkg;

  localparam int WIN_DEPTH = 32;
  localparam int IRQ_W     = 9;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [4:0] START_OFS    = 5'd0;
  localparam logic [4:0] FLAG_A_OFS   = 5'd4;
  localparam logic [4:0] FLAG_B_OFS   = 5'd5;
  localparam logic [4:0] FLAG_OVF_OFS = 5'd6;
  localparam int         CHAN_BASE    = 8;
  localparam int         CHAN_STRIDE  = 8;

  localparam logic [7:0] START_READ_ONES = 8'hf8;
  localparam logic [7:0] CLEAR_MODE_MASK = 8'h60;
  localparam logic [7:0] CLEAR_ON_A      = 8'h20;
  localparam logic [7:0] CLEAR_ON_B      = 8'h40;
  localparam logic [7:0] ENABLE_A_MASK   = 8'h03;
  localparam logic [7:0] ENABLE_B_MASK   = 8'h30;
  localparam logic [7:0] ENABLE_ANY_MASK = 8'h33;

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] reg_offset;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       read_data;
    logic [IRQ_W-1:0] irq_pulse;
  } out_item_t;

  typedef struct packed {
    logic       run;
    logic [2:0] psc;
  } chan_st_t;

  // Prescale period: 1, 2, 4 or 8 ticks.
  function automatic logic [3:0] period_of(input logic [1:0] sel);
    logic [3:0] p;
    case (sel)
      2'd0:    p = 4'd1;
      2'd1:    p = 4'd2;
      2'd2:    p = 4'd4;
      default: p = 4'd8;
    endcase
    return p;
  endfunction

endpackage

[hw/rtl/cmt_chan.sv]
// One channel's tick step: prescaler, count increment, compare and overflow flags.
module cmt_chan #(
  parameter int CH = 0
) (
  input  logic              tick_i,
  input  cmt_pkg::win_t     win_i,
  input  cmt_pkg::chan_st_t st_i,
  output cmt_pkg::win_t     win_o,
  output cmt_pkg::chan_st_t st_o,
  output logic [2:0]        irq_o
);

  localparam int B0 = (cmt_pkg::CHAN_BASE + cmt_pkg::CHAN_STRIDE * CH) % cmt_pkg::WIN_DEPTH;
  localparam int B1 = (B0 + 1) % cmt_pkg::WIN_DEPTH;
  localparam int B2 = (B0 + 2) % cmt_pkg::WIN_DEPTH;
  localparam int B3 = (B0 + 3) % cmt_pkg::WIN_DEPTH;
  localparam int B4 = (B0 + 4) % cmt_pkg::WIN_DEPTH;
  localparam int B5 = (B0 + 5) % cmt_pkg::WIN_DEPTH;
  localparam int B6 = (B0 + 6) % cmt_pkg::WIN_DEPTH;
  localparam int B7 = (B0 + 7) % cmt_pkg::WIN_DEPTH;
  localparam logic [7:0] CH_BIT = 8'(1 << CH);
  localparam int EN_BIT = CH + 2;

  logic [7:0]  ctrl;
  logic [7:0]  cen;
  logic [3:0]  psc_inc;
  logic        fire;
  logic [15:0] cnt;
  logic [15:0] cnt_a;
  logic [15:0] cnt_b;
  logic        clr_a;
  logic        clr_b;
  logic        match_a;
  logic        match_b;
  logic        ovf;
  logic [7:0]  flag_a;
  logic [7:0]  flag_b;
  logic [7:0]  flag_ovf;

  assign ctrl    = win_i[B0];
  assign cen     = win_i[B1];
  assign psc_inc = {1'b0, st_i.psc} + 4'd1;
  assign fire    = tick_i && st_i.run && (psc_inc >= cmt_pkg::period_of(ctrl[1:0]));

  assign clr_a   = (ctrl & cmt_pkg::CLEAR_MODE_MASK) == cmt_pkg::CLEAR_ON_A;
  assign clr_b   = (ctrl & cmt_pkg::CLEAR_MODE_MASK) == cmt_pkg::CLEAR_ON_B;
  assign cnt     = {win_i[B2], win_i[B3]} + 16'd1;
  assign match_a = ((cen & cmt_pkg::ENABLE_A_MASK) != 8'd0) && (cnt == {win_i[B4], win_i[B5]});
  assign cnt_a   = (match_a && clr_a) ? 16'd0 : cnt;
  assign match_b = ((cen & cmt_pkg::ENABLE_B_MASK) != 8'd0) && (cnt_a == {win_i[B6], win_i[B7]});
  assign cnt_b   = (match_b && clr_b) ? 16'd0 : cnt_a;
  assign ovf     = ((cen & cmt_pkg::ENABLE_ANY_MASK) == 8'd0) && (cnt_b == 16'd0);

  assign flag_a   = win_i[cmt_pkg::FLAG_A_OFS] | CH_BIT;
  assign flag_b   = win_i[cmt_pkg::FLAG_B_OFS] | CH_BIT;
  assign flag_ovf = win_i[cmt_pkg::FLAG_OVF_OFS] | CH_BIT;

  always_comb begin
    win_o = win_i;
    st_o  = st_i;
    irq_o = 3'b000;
    if (tick_i && st_i.run) begin
      if (fire) begin
        st_o.psc = 3'd0;
        if (match_b) begin
          st_o.run = clr_b;
        end else if (match_a) begin
          st_o.run = clr_a;
        end
        if (match_a) begin
          win_o[cmt_pkg::FLAG_A_OFS] = flag_a;
          irq_o[0] = flag_a[EN_BIT];
        end
        if (match_b) begin
          win_o[cmt_pkg::FLAG_B_OFS] = flag_b;
          irq_o[1] = flag_b[EN_BIT];
        end
        if (ovf) begin
          win_o[cmt_pkg::FLAG_OVF_OFS] = flag_ovf;
          irq_o[2] = flag_ovf[EN_BIT];
        end
        win_o[B2] = cnt_b[15:8];
        win_o[B3] = cnt_b[7:0];
      end else begin
        st_o.psc = psc_inc[2:0];
      end
    end
  end

endmodule

[hw/rtl/cmt_core.sv]
// Register window, channel state and per-item command execution.
module cmt_core #(
  parameter int CHANNELS = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go_i,
  input  cmt_pkg::in_item_t           item_i,
  output logic [7:0]                  rd_data_o,
  output logic [cmt_pkg::IRQ_W-1:0]   irq_o
);

  cmt_pkg::win_t     win_r;
  cmt_pkg::win_t     win_nxt;
  cmt_pkg::chan_st_t st_r   [CHANNELS];
  cmt_pkg::chan_st_t st_nxt [CHANNELS];

  cmt_pkg::win_t     win_chain [CHANNELS+1];
  cmt_pkg::chan_st_t st_tick   [CHANNELS];
  logic [2:0]        chan_irq  [CHANNELS];
  logic              tick;

  assign tick         = item_i.cmd == cmt_pkg::CMD_TICK;
  assign win_chain[0] = win_r;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    cmt_chan #(.CH(c)) u_chan (
      .tick_i (tick),
      .win_i  (win_chain[c]),
      .st_i   (st_r[c]),
      .win_o  (win_chain[c+1]),
      .st_o   (st_tick[c]),
      .irq_o  (chan_irq[c])
    );
  end

  for (genvar b = 0; b < cmt_pkg::IRQ_W; b++) begin : g_irq
    if (b / 3 < CHANNELS) begin : g_on
      assign irq_o[b] = tick && chan_irq[b / 3][b % 3];
    end else begin : g_off
      assign irq_o[b] = 1'b0;
    end
  end

  always_comb begin
    rd_data_o = 8'd0;
    if (item_i.cmd == cmt_pkg::CMD_READ) begin
      if (item_i.reg_offset == cmt_pkg::START_OFS) begin
        rd_data_o = win_r[cmt_pkg::START_OFS] | cmt_pkg::START_READ_ONES;
      end else begin
        rd_data_o = win_r[item_i.reg_offset];
      end
    end
  end

  always_comb begin
    win_nxt = win_r;
    for (int c = 0; c < CHANNELS; c++) begin
      st_nxt[c] = st_r[c];
    end
    if (go_i) begin
      case (item_i.cmd)
        cmt_pkg::CMD_TICK: begin
          win_nxt = win_chain[CHANNELS];
          for (int c = 0; c < CHANNELS; c++) begin
            st_nxt[c] = st_tick[c];
          end
        end
        cmt_pkg::CMD_WRITE: begin
          win_nxt[item_i.reg_offset] = item_i.write_data;
          if (item_i.reg_offset == cmt_pkg::START_OFS) begin
            for (int c = 0; c < CHANNELS; c++) begin
              if (!item_i.write_data[c]) begin
                st_nxt[c].run = 1'b0;
              end else if (!win_r[cmt_pkg::START_OFS][c]) begin
                st_nxt[c].run = 1'b1;
                st_nxt[c].psc = 3'd0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        st_r[c] <= '0;
      end
    end else begin
      win_r <= win_nxt;
      for (int c = 0; c < CHANNELS; c++) begin
        st_r[c] <= st_nxt[c];
      end
    end
  end

endmodule

[hw/rtl/compare_match_timer_unit.sv]
// Top level: input item register, command execution and result register.
// Each accepted item is held in the input register; its result goes to the result register.
// Throughput: one item per cycle while the output is not stalled; every tick runs
// in a single pass through the channel chain between the input and result registers.
// Reset: clears the register window, start byte, prescalers and stops all
// channels; both pipeline registers come up empty.
module compare_match_timer_unit #(
  parameter int CHANNELS = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cmt_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output cmt_pkg::out_item_t out_item
);

  logic               in_v_r;
  cmt_pkg::in_item_t  in_r;
  logic               out_v_r;
  cmt_pkg::out_item_t out_r;
  logic               advance;
  logic [7:0]         rd_data;
  logic [cmt_pkg::IRQ_W-1:0] irq;

  assign advance  = !out_v_r || !out_stall;
  assign in_stall = in_v_r && !advance;

  cmt_core #(.CHANNELS(CHANNELS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .go_i      (in_v_r && advance),
    .item_i    (in_r),
    .rd_data_o (rd_data),
    .irq_o     (irq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= in_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= in_item;
    end
    if (advance && in_v_r) begin
      out_r.read_data <= rd_data;
      out_r.irq_pulse <= irq;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

endmodule
